/* rtl/core/tocn_pkg.sv */
package tocn_pkg;

  // Width of each signed offset field on the input stream.
  localparam int OFFSET_BITS = 16;

  localparam int YEAR_W  = 14;
  localparam int DOY_W   = 9;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 6;
  localparam int MONTH_W = 4;
  localparam int MDAY_W  = 5;

  // Stream packing, first field in the lowest bits, padded to whole bytes.
  localparam int IN_BITS = YEAR_W + DOY_W + HOUR_W + MIN_W + SEC_W + 3 * OFFSET_BITS;
  localparam int IN_W    = ((IN_BITS + 7) / 8) * 8;
  localparam int IN_YEAR_LSB = 0;
  localparam int IN_DOY_LSB  = IN_YEAR_LSB + YEAR_W;
  localparam int IN_HOUR_LSB = IN_DOY_LSB + DOY_W;
  localparam int IN_MIN_LSB  = IN_HOUR_LSB + HOUR_W;
  localparam int IN_SEC_LSB  = IN_MIN_LSB + MIN_W;
  localparam int IN_OH_LSB   = IN_SEC_LSB + SEC_W;
  localparam int IN_OM_LSB   = IN_OH_LSB + OFFSET_BITS;
  localparam int IN_OS_LSB   = IN_OM_LSB + OFFSET_BITS;

  localparam int OUT_BITS = YEAR_W + DOY_W + MONTH_W + MDAY_W + HOUR_W + MIN_W + SEC_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;
  localparam int OUT_PAD  = OUT_W - OUT_BITS;

  // Signed working width of the carry sums and the day count; it also holds a base year.
  localparam int XW = (OFFSET_BITS + 2 > 15) ? OFFSET_BITS + 2 : 15;
  // Biased (non-negative) dividend width, reciprocal and quotient widths.
  localparam int UW = XW + 1;
  localparam int MW = UW - 4;
  localparam int QW = UW - 4;
  localparam int PW = UW + MW;
  localparam int DW = 9;
  localparam int RW = 10;
  localparam int YW = 15;
  localparam int MOD_W = 9;

  localparam logic [DW-1:0] DIV_SEC  = DW'(60);
  localparam logic [DW-1:0] DIV_HOUR = DW'(24);
  localparam logic [DW-1:0] DIV_YEAR = DW'(400);

  // Truncated reciprocals: the estimate is the true quotient or one below it.
  localparam logic [MW-1:0] RECIP_SEC  = MW'((64'd1 << UW) / 64'd60);
  localparam logic [MW-1:0] RECIP_HOUR = MW'((64'd1 << UW) / 64'd24);
  localparam logic [MW-1:0] RECIP_YEAR = MW'((64'd1 << UW) / 64'd400);

  // A multiple of the divisor is added so that the dividend is never negative;
  // the same count is taken off the quotient afterwards.
  localparam logic [UW-1:0] KQ_SEC    = UW'((64'd1 << (OFFSET_BITS + 1)) / 64'd60 + 64'd1);
  localparam logic [UW-1:0] KQ_HOUR   = UW'((64'd1 << (OFFSET_BITS + 1)) / 64'd24 + 64'd1);
  localparam logic [UW-1:0] BIAS_SEC  = UW'(64'd60 * ((64'd1 << (OFFSET_BITS + 1)) / 64'd60
                                                      + 64'd1));
  localparam logic [UW-1:0] BIAS_HOUR = UW'(64'd24 * ((64'd1 << (OFFSET_BITS + 1)) / 64'd24
                                                      + 64'd1));
  localparam logic [UW-1:0] ADJ_MIN   = BIAS_SEC - KQ_SEC;
  localparam logic [UW-1:0] ADJ_HOUR  = BIAS_HOUR - KQ_SEC;
  localparam logic [XW-1:0] DAY_ADJ   = KQ_HOUR[XW-1:0];

  localparam logic signed [YW-1:0] YEAR_MAX     = YW'(9999);
  localparam logic signed [YW-1:0] YEAR_CENTURY = YW'(100);
  localparam logic [DOY_W-1:0]     LEN_COMMON   = DOY_W'(365);
  localparam logic [DOY_W-1:0]     LEN_LEAP     = DOY_W'(366);
  localparam logic [MOD_W-1:0]     MOD_LAST     = MOD_W'(399);

  // Gregorian rule; years below 100 count as 19xx. y400 is the year modulo 400.
  function automatic logic is_leap(input logic signed [YW-1:0] yr,
                                   input logic [MOD_W-1:0] y400);
    logic div4;
    div4 = (yr[1:0] == 2'b00);
    if (yr < YEAR_CENTURY) begin
      return div4 && (yr != '0);
    end
    return div4 && (y400 != MOD_W'(100)) && (y400 != MOD_W'(200)) &&
           (y400 != MOD_W'(300));
  endfunction

  function automatic logic [MDAY_W-1:0] month_len(input logic leap,
                                                  input logic [MONTH_W-1:0] idx);
    logic [MDAY_W-1:0] len;
    unique case (idx)
      4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
      4'd3, 4'd5, 4'd8, 4'd10:                   len = 5'd30;
      4'd1:    len = leap ? 5'd29 : 5'd28;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

/* rtl/core/time_offset_calendar_normalizer.sv */
// Adds a signed hour/minute/second offset to a timestamp given as year, day of
// year, hour, minute and second, and returns the normalized year, day of year,
// month, day of month and time of day.
// Input stream (s_axis_*): one item per timestamp; an item is taken when
// s_axis_tvalid and s_axis_tready are both high. Output stream (m_axis_*):
// exactly one result item per input item, in order.
// A single divide-by-constant unit (reciprocal multiply, remainder, correction)
// is run four times: year modulo 400, then the second, minute and hour carries.
// The day count then crosses year boundaries one year per cycle, and the month
// search walks the month table one month per cycle.
// One item is in work at a time: the block takes no new timestamp before its
// result is loaded, and s_axis_tready goes high again in the cycle after that.
// The result sits in an output register, so the next item is accepted while a
// result waits; if m_axis_tready stays low, the next finished result waits
// inside the block until the register is free, and s_axis_tready stays low.
// Synchronous reset (rst) returns the sequencer to idle and drops the output
// valid; it holds no other state.
module time_offset_calendar_normalizer (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // base_year, base_day_of_year, base_hour, base_minute, base_second,
  // offset_hours, offset_minutes, offset_seconds
  input  logic [tocn_pkg::IN_W-1:0]  s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // out_year, out_day_of_year, out_month, out_day, out_hour, out_minute, out_second
  output logic [tocn_pkg::OUT_W-1:0] m_axis_tdata,
  // year_clamped
  output logic                       m_axis_tuser
);

  localparam int OB = tocn_pkg::OFFSET_BITS;
  localparam int XW = tocn_pkg::XW;
  localparam int UW = tocn_pkg::UW;
  localparam int MW = tocn_pkg::MW;
  localparam int QW = tocn_pkg::QW;
  localparam int PW = tocn_pkg::PW;
  localparam int DW = tocn_pkg::DW;
  localparam int RW = tocn_pkg::RW;
  localparam int YW = tocn_pkg::YW;
  localparam int MOD_W = tocn_pkg::MOD_W;

  // Sequencer states.
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL   = 4'd1;
  localparam logic [3:0] S_REM   = 4'd2;
  localparam logic [3:0] S_FIX   = 4'd3;
  localparam logic [3:0] S_NEXT  = 4'd4;
  localparam logic [3:0] S_FWD   = 4'd5;
  localparam logic [3:0] S_BWD   = 4'd6;
  localparam logic [3:0] S_CLAMP = 4'd7;
  localparam logic [3:0] S_MON   = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  // Which division the shared unit is doing.
  localparam logic [1:0] PH_YEAR = 2'd0;
  localparam logic [1:0] PH_SEC  = 2'd1;
  localparam logic [1:0] PH_MIN  = 2'd2;
  localparam logic [1:0] PH_HOUR = 2'd3;

  logic [3:0]             state;
  logic [1:0]             phase;
  logic [UW-1:0]          xb;
  logic [PW-1:0]          prod;
  logic [QW-1:0]          qk;
  logic [RW-1:0]          rem;
  logic signed [YW-1:0]   yr;
  logic [MOD_W-1:0]       y400;
  logic signed [XW-1:0]   jd;
  logic [4:0]             hr;
  logic [5:0]             mi;
  logic [5:0]             sc;
  logic signed [OB-1:0]   oh;
  logic signed [OB-1:0]   om;
  logic signed [OB-1:0]   os;
  logic                   clamped;
  logic [3:0]             midx;
  logic [8:0]             left;

  // Shared divide-by-constant unit.
  logic [DW-1:0]          d_sel;
  logic [MW-1:0]          m_sel;
  logic [QW-1:0]          q0;
  logic [QW+DW-1:0]       qd_full;
  logic [UW-1:0]          diff;
  logic                   inc;
  logic [RW-1:0]          r_fin;

  always_comb begin
    unique case (phase)
      PH_YEAR: begin
        d_sel = tocn_pkg::DIV_YEAR;
        m_sel = tocn_pkg::RECIP_YEAR;
      end
      PH_SEC, PH_MIN: begin
        d_sel = tocn_pkg::DIV_SEC;
        m_sel = tocn_pkg::RECIP_SEC;
      end
      PH_HOUR: begin
        d_sel = tocn_pkg::DIV_HOUR;
        m_sel = tocn_pkg::RECIP_HOUR;
      end
      default: begin
        d_sel = tocn_pkg::DIV_SEC;
        m_sel = tocn_pkg::RECIP_SEC;
      end
    endcase
  end

  assign q0      = prod[PW-1:UW];
  assign qd_full = q0 * d_sel;
  assign diff    = xb - qd_full[UW-1:0];
  // The estimate is at most one short, so one compare and subtract finishes it.
  assign inc     = (rem >= {1'b0, d_sel});
  assign r_fin   = rem - (inc ? {1'b0, d_sel} : '0);

  // Next dividends: base field plus offset plus the carry, with the bias folded in.
  logic [UW-1:0] os_x, om_x, oh_x, qk_x;
  logic [UW-1:0] xb_sec, xb_min, xb_hour;
  logic signed [XW-1:0] jd_days;

  assign os_x    = {{(UW-OB){os[OB-1]}}, os};
  assign om_x    = {{(UW-OB){om[OB-1]}}, om};
  assign oh_x    = {{(UW-OB){oh[OB-1]}}, oh};
  assign qk_x    = {{(UW-QW){1'b0}}, qk};
  assign xb_sec  = UW'(sc) + os_x + tocn_pkg::BIAS_SEC;
  assign xb_min  = UW'(mi) + om_x + qk_x + tocn_pkg::ADJ_MIN;
  assign xb_hour = UW'(hr) + oh_x + qk_x + tocn_pkg::ADJ_HOUR;
  assign jd_days = jd + $signed(XW'(qk)) - $signed(tocn_pkg::DAY_ADJ);

  // Year rollover.
  logic signed [YW-1:0] yr_m1;
  logic [MOD_W-1:0]     y400_p1, y400_m1;
  logic [8:0]           len_cur, len_m1;
  logic signed [XW-1:0] len_cur_s, len_m1_s;
  logic                 step_fwd, step_bwd;

  assign yr_m1     = yr - YW'(1);
  assign y400_p1   = (y400 == tocn_pkg::MOD_LAST) ? '0 : y400 + MOD_W'(1);
  assign y400_m1   = (y400 == '0) ? tocn_pkg::MOD_LAST : y400 - MOD_W'(1);
  assign len_cur   = tocn_pkg::is_leap(yr, y400) ? tocn_pkg::LEN_LEAP : tocn_pkg::LEN_COMMON;
  assign len_m1    = tocn_pkg::is_leap(yr_m1, y400_m1) ? tocn_pkg::LEN_LEAP
                                                       : tocn_pkg::LEN_COMMON;
  assign len_cur_s = $signed(XW'(len_cur));
  assign len_m1_s  = $signed(XW'(len_m1));
  assign step_fwd  = (jd > len_cur_s) && (yr <= tocn_pkg::YEAR_MAX);
  assign step_bwd  = (jd < $signed(XW'(1))) && !yr[YW-1];

  // Month search.
  logic [4:0] mlen;
  logic       step_mon;

  assign mlen     = tocn_pkg::month_len(tocn_pkg::is_leap(yr, y400), midx);
  assign step_mon = (midx < 4'd11) && (left > {4'b0, mlen});

  assign s_axis_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && (state != S_DONE)) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            yr    <= $signed(YW'(s_axis_tdata[tocn_pkg::IN_YEAR_LSB +: tocn_pkg::YEAR_W]));
            jd    <= $signed(XW'(s_axis_tdata[tocn_pkg::IN_DOY_LSB +: tocn_pkg::DOY_W]));
            hr    <= s_axis_tdata[tocn_pkg::IN_HOUR_LSB +: tocn_pkg::HOUR_W];
            mi    <= s_axis_tdata[tocn_pkg::IN_MIN_LSB +: tocn_pkg::MIN_W];
            sc    <= s_axis_tdata[tocn_pkg::IN_SEC_LSB +: tocn_pkg::SEC_W];
            oh    <= s_axis_tdata[tocn_pkg::IN_OH_LSB +: OB];
            om    <= s_axis_tdata[tocn_pkg::IN_OM_LSB +: OB];
            os    <= s_axis_tdata[tocn_pkg::IN_OS_LSB +: OB];
            xb    <= UW'(s_axis_tdata[tocn_pkg::IN_YEAR_LSB +: tocn_pkg::YEAR_W]);
            phase <= PH_YEAR;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= xb * m_sel;
          state <= S_REM;
        end
        S_REM: begin
          qk    <= q0;
          rem   <= diff[RW-1:0];
          state <= S_FIX;
        end
        S_FIX: begin
          qk <= qk + QW'(inc);
          unique case (phase)
            PH_YEAR: y400 <= r_fin[MOD_W-1:0];
            PH_SEC:  sc   <= r_fin[5:0];
            PH_MIN:  mi   <= r_fin[5:0];
            PH_HOUR: hr   <= r_fin[4:0];
            default: hr   <= r_fin[4:0];
          endcase
          state <= S_NEXT;
        end
        S_NEXT: begin
          unique case (phase)
            PH_YEAR: begin
              xb    <= xb_sec;
              phase <= PH_SEC;
              state <= S_MUL;
            end
            PH_SEC: begin
              xb    <= xb_min;
              phase <= PH_MIN;
              state <= S_MUL;
            end
            PH_MIN: begin
              xb    <= xb_hour;
              phase <= PH_HOUR;
              state <= S_MUL;
            end
            default: begin
              jd    <= jd_days;
              state <= S_FWD;
            end
          endcase
        end
        S_FWD: begin
          if (step_fwd) begin
            jd   <= jd - len_cur_s;
            yr   <= yr + YW'(1);
            y400 <= y400_p1;
          end else begin
            state <= S_BWD;
          end
        end
        S_BWD: begin
          if (step_bwd) begin
            jd   <= jd + len_m1_s;
            yr   <= yr_m1;
            y400 <= y400_m1;
          end else begin
            state <= S_CLAMP;
          end
        end
        S_CLAMP: begin
          midx <= '0;
          priority if (yr[YW-1]) begin
            clamped <= 1'b1;
            yr      <= '0;
            jd      <= $signed(XW'(1));
            left    <= 9'd1;
            hr      <= '0;
            mi      <= '0;
            sc      <= '0;
          end else if (yr > tocn_pkg::YEAR_MAX) begin
            // Year 9999 is a common year, so the last day is day 365.
            clamped <= 1'b1;
            yr      <= tocn_pkg::YEAR_MAX;
            jd      <= $signed(XW'(tocn_pkg::LEN_COMMON));
            left    <= tocn_pkg::LEN_COMMON;
            hr      <= 5'd23;
            mi      <= 6'd59;
            sc      <= 6'd59;
          end else begin
            clamped <= 1'b0;
            left    <= jd[8:0];
          end
          state <= S_MON;
        end
        S_MON: begin
          if (step_mon) begin
            left <= left - {4'b0, mlen};
            midx <= midx + 4'd1;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tdata  <= {{tocn_pkg::OUT_PAD{1'b0}}, sc, mi, hr, left[4:0],
                              4'(midx + 4'd1), jd[8:0], yr[tocn_pkg::YEAR_W-1:0]};
            m_axis_tuser  <= clamped;
            m_axis_tvalid <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The reciprocal estimate is never more than one short.
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_FIX |-> rem < ({1'b0, d_sel} << 1))
    else $error("divider remainder out of range");

  // An accepted item always starts with the year-modulo pass.
  a_start: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> state == S_MUL && phase == PH_YEAR)
    else $error("item did not start the divide sequence");

  // The month search always works on a day that exists.
  a_mon_left: assert property (@(posedge clk) disable iff (rst)
    state == S_MON |-> left != '0 && left <= 9'd366)
    else $error("month search day count out of range");

  // A freshly loaded result carries a valid month and day of month.
  a_result: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && (!m_axis_tvalid || m_axis_tready) |=>
      m_axis_tdata[26:23] != '0 && m_axis_tdata[26:23] <= 4'd12 &&
      m_axis_tdata[31:27] != '0)
    else $error("result month or day out of range");

endmodule

/* tb/tb_time_offset_calendar_normalizer.sv */
`timescale 1ns / 100ps

module tb_time_offset_calendar_normalizer;

  localparam int YEAR_W      = tocn_pkg::YEAR_W;
  localparam int DOY_W       = tocn_pkg::DOY_W;
  localparam int HOUR_W      = tocn_pkg::HOUR_W;
  localparam int MIN_W       = tocn_pkg::MIN_W;
  localparam int SEC_W       = tocn_pkg::SEC_W;
  localparam int MONTH_W     = tocn_pkg::MONTH_W;
  localparam int MDAY_W      = tocn_pkg::MDAY_W;
  localparam int OFFSET_BITS = tocn_pkg::OFFSET_BITS;
  localparam int IN_W        = tocn_pkg::IN_W;
  localparam int OUT_W       = tocn_pkg::OUT_W;

  // Bit offsets of the result fields inside m_axis_tdata, lowest field first.
  localparam int O_DOY  = YEAR_W;
  localparam int O_MON  = O_DOY + DOY_W;
  localparam int O_MDAY = O_MON + MONTH_W;
  localparam int O_HOUR = O_MDAY + MDAY_W;
  localparam int O_MIN  = O_HOUR + HOUR_W;
  localparam int O_SEC  = O_MIN + MIN_W;

  localparam int LAST_YEAR      = 9999;
  localparam int RESET_CYCLES   = 11;
  localparam int RANDOM_ITEMS   = 1330;
  // Every item finishes and each side's idle gaps are bounded by draw_gap, so a
  // long silence on both streams means a hang.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 80;

  // One timestamp plus the offset to apply to it.
  typedef struct {
    logic [YEAR_W-1:0]             year;
    logic [DOY_W-1:0]              doy;
    logic [HOUR_W-1:0]             hour;
    logic [MIN_W-1:0]              minute;
    logic [SEC_W-1:0]              second;
    logic signed [OFFSET_BITS-1:0] off_h;
    logic signed [OFFSET_BITS-1:0] off_m;
    logic signed [OFFSET_BITS-1:0] off_s;
  } stamp_t;

  // One normalized calendar date with time of day.
  typedef struct {
    logic [YEAR_W-1:0]  year;
    logic [DOY_W-1:0]   doy;
    logic [MONTH_W-1:0] month;
    logic [MDAY_W-1:0]  mday;
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minute;
    logic [SEC_W-1:0]   second;
    logic               clamped;
  } date_t;

  // A directed row either carries its result typed in, or leaves it to the predictor.
  typedef struct {
    stamp_t stim;
    bit     literal;
    date_t  want;
  } row_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [IN_W-1:0]     s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OUT_W-1:0]    m_axis_tdata;
  logic                m_axis_tuser;

  date_t pending_dates[$];
  row_t  plan[$];
  int    mismatch_count = 0;
  int    idle_cycles = 0;
  int    send_calm = 0;
  int    recv_calm = 0;

  time_offset_calendar_normalizer dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Calendar arithmetic used by the predictor.
  // ---------------------------------------------------------------------

  // Gregorian rule; a year below 100 is tested as 19xx.
  function automatic bit leap_year(input longint yr);
    longint y;
    y = (yr < 100) ? yr + 1900 : yr;
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic longint year_days(input longint yr);
    return leap_year(yr) ? 366 : 365;
  endfunction

  function automatic longint days_in_month(input bit leap, input int m);
    case (m)
      1:          return leap ? 29 : 28;
      3, 5, 8, 10: return 30;
      default:    return 31;
    endcase
  endfunction

  // Division rounding toward minus infinity, with a remainder in 0..d-1.
  function automatic longint floor_div(input longint a, input longint d, output longint r);
    longint q;
    q = a / d;
    r = a % d;
    if (r < 0) begin
      r = r + d;
      q = q - 1;
    end
    return q;
  endfunction

  // Predicts the block's result for one timestamp.
  function automatic date_t normalize_stamp(input stamp_t s);
    longint yr, jd, hr, mi, sc, carry, left;
    int     m;
    bit     leap, clamped;
    date_t  d;
    yr = longint'(s.year);
    jd = longint'(s.doy);
    hr = longint'(s.hour);
    mi = longint'(s.minute);
    sc = longint'(s.second);
    clamped = 1'b0;

    // Carry seconds into minutes, minutes into hours and hours into days.
    carry = floor_div(sc + longint'(s.off_s), 60, sc);
    carry = floor_div(mi + longint'(s.off_m) + carry, 60, mi);
    jd = jd + floor_div(hr + longint'(s.off_h) + carry, 24, hr);

    // Cross year boundaries one year at a time. Going forward, the full length
    // of the year being left is taken off, so leftover days are kept.
    while (jd > year_days(yr) && yr <= LAST_YEAR) begin
      jd = jd - year_days(yr);
      yr = yr + 1;
    end
    while (jd < 1 && yr >= 0) begin
      yr = yr - 1;
      jd = jd + year_days(yr);
    end

    // Out of range years saturate the whole result.
    if (yr < 0) begin
      clamped = 1'b1;
      yr = 0; jd = 1; hr = 0; mi = 0; sc = 0;
    end else if (yr > LAST_YEAR) begin
      clamped = 1'b1;
      yr = LAST_YEAR; jd = year_days(LAST_YEAR); hr = 23; mi = 59; sc = 59;
    end

    // Walk the month table; December takes whatever is left.
    leap = leap_year(yr);
    left = jd;
    m = 0;
    while (m < 11 && left > days_in_month(leap, m)) begin
      left = left - days_in_month(leap, m);
      m++;
    end

    d.year    = YEAR_W'(yr);
    d.doy     = DOY_W'(jd);
    d.month   = MONTH_W'(m + 1);
    d.mday    = MDAY_W'(left);
    d.hour    = HOUR_W'(hr);
    d.minute  = MIN_W'(mi);
    d.second  = SEC_W'(sc);
    d.clamped = clamped;
    return d;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus construction.
  // ---------------------------------------------------------------------

  function automatic stamp_t mk_stamp(input int yr, input int doy, input int hr,
                                      input int mi, input int sc, input int oh,
                                      input int om, input int os);
    stamp_t s;
    s.year   = YEAR_W'(yr);
    s.doy    = DOY_W'(doy);
    s.hour   = HOUR_W'(hr);
    s.minute = MIN_W'(mi);
    s.second = SEC_W'(sc);
    s.off_h  = OFFSET_BITS'(oh);
    s.off_m  = OFFSET_BITS'(om);
    s.off_s  = OFFSET_BITS'(os);
    return s;
  endfunction

  function automatic date_t mk_date(input int yr, input int doy, input int mon,
                                    input int mday, input int hr, input int mi,
                                    input int sc, input bit cl);
    date_t d;
    d.year    = YEAR_W'(yr);
    d.doy     = DOY_W'(doy);
    d.month   = MONTH_W'(mon);
    d.mday    = MDAY_W'(mday);
    d.hour    = HOUR_W'(hr);
    d.minute  = MIN_W'(mi);
    d.second  = SEC_W'(sc);
    d.clamped = cl;
    return d;
  endfunction

  function automatic row_t given(input stamp_t s, input date_t d);
    row_t r;
    r.stim = s;
    r.literal = 1'b1;
    r.want = d;
    return r;
  endfunction

  function automatic row_t derived(input stamp_t s);
    row_t r;
    r.stim = s;
    r.literal = 1'b0;
    r.want = mk_date(0, 0, 0, 0, 0, 0, 0, 1'b0);
    return r;
  endfunction

  // Offsets come in several magnitudes so that carries of every size occur.
  function automatic logic signed [OFFSET_BITS-1:0] rand_offset();
    int v;
    case ($urandom_range(0, 4))
      0:       v = 0;
      1:       v = int'($urandom_range(0, 240)) - 120;
      2:       v = int'($urandom_range(0, 4000)) - 2000;
      default: v = int'($urandom_range(0, 65535));
    endcase
    return OFFSET_BITS'(v);
  endfunction

  function automatic stamp_t random_stamp();
    stamp_t s;
    int     kind, yr;
    kind = $urandom_range(0, 99);
    if (kind < 60) begin
      // Well-formed timestamp with an offset of any size.
      yr = $urandom_range(0, LAST_YEAR);
      s = mk_stamp(yr, $urandom_range(1, int'(year_days(yr))), $urandom_range(0, 23),
                   $urandom_range(0, 59), $urandom_range(0, 59), 0, 0, 0);
      s.off_h = rand_offset();
      s.off_m = rand_offset();
      s.off_s = rand_offset();
    end else if (kind < 75) begin
      // Close to a year boundary, with an hour offset of up to two days either way.
      yr = $urandom_range(0, LAST_YEAR);
      s = mk_stamp(yr, ($urandom_range(0, 1) != 0) ? $urandom_range(1, 2)
                                                 : $urandom_range(364, int'(year_days(yr))),
                   ($urandom_range(0, 1) != 0) ? 0 : 23, $urandom_range(0, 59),
                   $urandom_range(0, 59), int'($urandom_range(0, 96)) - 48,
                   int'($urandom_range(0, 240)) - 120, int'($urandom_range(0, 240)) - 120);
    end else if (kind < 85) begin
      // Near either end of the year range, where the result may saturate.
      yr = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 4)
                                       : $urandom_range(LAST_YEAR - 4, LAST_YEAR);
      s = mk_stamp(yr, $urandom_range(1, int'(year_days(yr))), $urandom_range(0, 23),
                   $urandom_range(0, 59), $urandom_range(0, 59), 0, 0, 0);
      s.off_h = rand_offset();
      s.off_m = rand_offset();
      s.off_s = rand_offset();
    end else begin
      // Every field anywhere in its bit width.
      s = mk_stamp($urandom_range(0, 16383), $urandom_range(0, 511), $urandom_range(0, 31),
                   $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 65535),
                   $urandom_range(0, 65535), $urandom_range(0, 65535));
    end
    return s;
  endfunction

  // Per item idle count; now and then a run of items goes with no idling at all.
  function automatic int draw_gap(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm_left = $urandom_range(10, 40);
    end
    return $urandom_range(0, 14);
  endfunction

  // ---------------------------------------------------------------------
  // Input side: offers one item and records its expected result once taken.
  // ---------------------------------------------------------------------
  task automatic offer_stamp(input stamp_t stim, input date_t want);
    int gap;
    gap = draw_gap(send_calm);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_W'({stim.off_s, stim.off_m, stim.off_h, stim.second,
                            stim.minute, stim.hour, stim.doy, stim.year});
    // tready is read before the edge updates settle, so this is the value the
    // block itself saw at the edge.
    do @(posedge clk); while (s_axis_tready !== 1'b1);
    pending_dates.push_back(want);
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // ---------------------------------------------------------------------
  // Output side: stalls at random and checks each accepted result against
  // the oldest expectation.
  // ---------------------------------------------------------------------
  initial begin : result_sink
    date_t want;
    int    gap;
    m_axis_tready <= 1'b0;
    @(posedge clk);
    forever begin
      gap = draw_gap(recv_calm);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (m_axis_tvalid !== 1'b1);
      if (pending_dates.size() == 0) begin
        $display("%0t: result item with no expectation waiting, actual tdata %h tuser %b",
                 $time, m_axis_tdata, m_axis_tuser);
        mismatch_count++;
      end else begin
        want = pending_dates.pop_front();
        check_field("year",         16'(want.year),    16'(m_axis_tdata[0 +: YEAR_W]));
        check_field("day of year",  16'(want.doy),     16'(m_axis_tdata[O_DOY +: DOY_W]));
        check_field("month",        16'(want.month),   16'(m_axis_tdata[O_MON +: MONTH_W]));
        check_field("day of month", 16'(want.mday),    16'(m_axis_tdata[O_MDAY +: MDAY_W]));
        check_field("hour",         16'(want.hour),    16'(m_axis_tdata[O_HOUR +: HOUR_W]));
        check_field("minute",       16'(want.minute),  16'(m_axis_tdata[O_MIN +: MIN_W]));
        check_field("second",       16'(want.second),  16'(m_axis_tdata[O_SEC +: SEC_W]));
        check_field("year_clamped", 16'(want.clamped), 16'(m_axis_tuser));
      end
    end
  end

  // A hang shows up as a long stretch with no item moving on either side.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("time_offset_calendar_normalizer test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence: reset, directed table, random items, drain.
  // ---------------------------------------------------------------------
  initial begin : main_sequence
    stamp_t s;
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;

    // Plain case right after reset, with no offset at all.
    plan.push_back(given(mk_stamp(2000, 1, 0, 0, 0, 0, 0, 0),
                         mk_date(2000, 1, 1, 1, 0, 0, 0, 1'b0)));
    plan.push_back(given(mk_stamp(0, 1, 0, 0, 0, 0, 0, 0),
                         mk_date(0, 1, 1, 1, 0, 0, 0, 1'b0)));
    plan.push_back(given(mk_stamp(9999, 365, 23, 59, 59, 0, 0, 0),
                         mk_date(9999, 365, 12, 31, 23, 59, 59, 1'b0)));
    // Saturation below year 0 and above year 9999.
    plan.push_back(given(mk_stamp(0, 1, 0, 0, 0, -32768, 0, 0),
                         mk_date(0, 1, 1, 1, 0, 0, 0, 1'b1)));
    plan.push_back(given(mk_stamp(0, 1, 0, 0, 0, -32768, -32768, -32768),
                         mk_date(0, 1, 1, 1, 0, 0, 0, 1'b1)));
    plan.push_back(given(mk_stamp(9999, 365, 23, 59, 59, 0, 0, 1),
                         mk_date(9999, 365, 12, 31, 23, 59, 59, 1'b1)));
    plan.push_back(given(mk_stamp(9999, 365, 0, 0, 0, 32767, 32767, 32767),
                         mk_date(9999, 365, 12, 31, 23, 59, 59, 1'b1)));
    // A base year above 9999 that stays out of range.
    plan.push_back(given(mk_stamp(16383, 1, 0, 0, 0, 0, 0, 0),
                         mk_date(9999, 365, 12, 31, 23, 59, 59, 1'b1)));
    plan.push_back(derived(mk_stamp(16383, 0, 0, 0, 0, -32768, -32768, -32768)));
    // A base year above 9999 that comes back in range.
    plan.push_back(derived(mk_stamp(10000, 1, 0, 0, 0, -24, 0, 0)));
    // Year 0 counts as 1900 and has no leap day; years 96 and 99 as 1996 and 1999.
    plan.push_back(derived(mk_stamp(0, 366, 0, 0, 0, 0, 0, 0)));
    plan.push_back(derived(mk_stamp(96, 366, 12, 0, 0, 0, 0, 0)));
    plan.push_back(derived(mk_stamp(99, 366, 12, 0, 0, 0, 0, 0)));
    // Century rules: 1900 and 2100 common, 2000 and 2400 leap.
    plan.push_back(derived(mk_stamp(2000, 60, 0, 0, 0, 0, 0, 0)));
    plan.push_back(derived(mk_stamp(1900, 60, 0, 0, 0, 0, 0, 0)));
    plan.push_back(derived(mk_stamp(2100, 365, 0, 0, 0, 24, 0, 0)));
    plan.push_back(derived(mk_stamp(2400, 366, 23, 59, 59, 0, 0, 1)));
    // Forward rollover keeps the leftover days; backward rollover by one second.
    plan.push_back(derived(mk_stamp(2023, 365, 0, 0, 0, 24, 0, 0)));
    plan.push_back(derived(mk_stamp(2024, 366, 23, 0, 0, 48, 0, 0)));
    plan.push_back(derived(mk_stamp(2001, 1, 0, 0, 0, 0, 0, -1)));
    // Base fields beyond their ranges, and day of year 0.
    plan.push_back(derived(mk_stamp(2010, 511, 31, 63, 63, 0, 0, 0)));
    plan.push_back(derived(mk_stamp(2010, 0, 0, 0, 0, 0, 0, 0)));
    // Largest offsets both ways, and offsets of mixed sign.
    plan.push_back(derived(mk_stamp(2000, 1, 0, 0, 0, 32767, 32767, 32767)));
    plan.push_back(derived(mk_stamp(5000, 200, 12, 30, 30, -32768, -32768, -32768)));
    plan.push_back(derived(mk_stamp(1999, 335, 7, 15, 45, -5000, 32767, -32768)));

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      offer_stamp(plan[i].stim, plan[i].literal ? plan[i].want
                                                : normalize_stamp(plan[i].stim));
    end

    repeat (RANDOM_ITEMS) begin
      s = random_stamp();
      offer_stamp(s, normalize_stamp(s));
    end
    s_axis_tvalid <= 1'b0;

    // Let every expected result arrive, then watch a while for stray results.
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("time_offset_calendar_normalizer test passed");
    end else begin
      $display("time_offset_calendar_normalizer test failed");
    end
    $finish;
  end

endmodule
